/* hw/rtl/ost_pkg.sv */
// Shared types and codes for the one-shot timer bank.
// No dependencies; imported by the output stage and the top level.
package ost_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_CMD    = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] slot;
        logic       ok;
        logic       last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_ALLOC,
        ST_TK_RD,
        ST_TK_UPD,
        ST_TK_END
    } t_state;

endpackage

/* hw/rtl/one_shot_timer_bank.sv */
// A bank of NUM_SLOTS one-shot timers driven by one sequencer and one shared
// decrementer. The block takes one item at a time and stalls its input until
// the last result of that item has been loaded into the output register. An
// allocate walks the in-use flags one slot per cycle; a tick walks all slots,
// passing over an unarmed slot and, on an armed one, reading the count memory,
// then decrementing and writing back. An output stall can hold an item back
// further. The count memory needs no clearing pass; a count is only read after
// a start has written it.
// Depends on ost_pkg and ost_out_reg.
module one_shot_timer_bank
    import ost_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_timer_id,
    input  logic [31:0] i_seconds,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [3:0]  o_slot_id,
    output logic        o_ok,
    output logic        o_last
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

    t_state r_state, n_state;

    logic [1:0]           r_op;
    logic [3:0]           r_id;
    logic [31:0]          r_secs;
    logic [SW-1:0]        r_idx, n_idx;
    logic [NUM_SLOTS-1:0] r_use, n_use;
    logic [NUM_SLOTS-1:0] r_armed, n_armed;
    logic                 r_pv, n_pv;
    logic [SW-1:0]        r_pslot, n_pslot;
    logic [31:0]          r_ticks [NUM_SLOTS];
    logic [31:0]          r_rd_data;

    logic          in_xfer;
    logic          out_free;
    logic          ld;
    t_result       res;
    t_result       out_res;
    logic          mem_we;
    logic [SW-1:0] mem_wa;
    logic [31:0]   mem_wd;
    logic [SW-1:0] id_idx;
    logic          id_ok;
    logic          idx_last;
    logic          cur_use;
    logic          cur_armed;
    logic          expire;
    logic          tk_blocked;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    assign id_idx    = SW'(r_id);
    assign id_ok     = (32'(r_id) < NUM_SLOTS) && r_use[id_idx];
    assign idx_last  = (r_idx == LAST_IDX);
    assign cur_use   = r_use[r_idx];
    assign cur_armed = r_armed[r_idx];
    assign expire    = (r_rd_data <= 32'd1);
    // A second expiry can only be found once the held one has left.
    assign tk_blocked = expire && r_pv && !out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (i_opcode)
                        OP_TICK:  n_state = ST_TK_RD;
                        OP_ALLOC: n_state = ST_ALLOC;
                        default:  n_state = ST_CMD;
                    endcase
                end
            end
            ST_CMD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ALLOC: begin
                if (out_free && (!cur_use || idx_last)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TK_RD: begin
                if (cur_armed) begin
                    n_state = ST_TK_UPD;
                end else if (idx_last) begin
                    n_state = ST_TK_END;
                end
            end
            ST_TK_UPD: begin
                if (!tk_blocked) begin
                    n_state = idx_last ? ST_TK_END : ST_TK_RD;
                end
            end
            ST_TK_END: begin
                if (!r_pv || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control.
    always_comb begin
        ld      = 1'b0;
        res     = '0;
        mem_we  = 1'b0;
        mem_wa  = r_idx;
        mem_wd  = r_rd_data - 32'd1;
        n_idx   = r_idx;
        n_use   = r_use;
        n_armed = r_armed;
        n_pv    = r_pv;
        n_pslot = r_pslot;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
            end
            ST_CMD: begin
                if (out_free) begin
                    ld        = 1'b1;
                    res.kind  = KIND_CMD;
                    res.slot  = r_id;
                    res.ok    = id_ok;
                    res.last  = 1'b1;
                    if (id_ok) begin
                        if (r_op == OP_START) begin
                            n_armed[id_idx] = 1'b1;
                            mem_we          = 1'b1;
                            mem_wa          = id_idx;
                            mem_wd          = r_secs;
                        end else begin
                            n_armed[id_idx] = 1'b0;
                        end
                    end
                end
            end
            ST_ALLOC: begin
                if (!cur_use) begin
                    if (out_free) begin
                        ld             = 1'b1;
                        res.kind       = KIND_ALLOC;
                        res.slot       = 4'(r_idx);
                        res.ok         = 1'b1;
                        res.last       = 1'b1;
                        n_use[r_idx]   = 1'b1;
                        n_armed[r_idx] = 1'b0;
                    end
                end else if (idx_last) begin
                    if (out_free) begin
                        ld       = 1'b1;
                        res.kind = KIND_ALLOC;
                        res.slot = '0;
                        res.ok   = 1'b0;
                        res.last = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TK_RD: begin
                if (!cur_armed && !idx_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TK_UPD: begin
                if (!tk_blocked) begin
                    if (expire) begin
                        // The held expiry is not the last one; pass it on.
                        if (r_pv) begin
                            ld       = 1'b1;
                            res.kind = KIND_EXPIRY;
                            res.slot = 4'(r_pslot);
                            res.ok   = 1'b1;
                            res.last = 1'b0;
                        end
                        n_pv           = 1'b1;
                        n_pslot        = r_idx;
                        n_use[r_idx]   = 1'b0;
                        n_armed[r_idx] = 1'b0;
                    end else begin
                        mem_we = 1'b1;
                    end
                    if (!idx_last) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_TK_END: begin
                if (r_pv && out_free) begin
                    ld       = 1'b1;
                    res.kind = KIND_EXPIRY;
                    res.slot = 4'(r_pslot);
                    res.ok   = 1'b1;
                    res.last = 1'b1;
                    n_pv     = 1'b0;
                end
            end
            default: begin
                n_pv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_use   <= '0;
            r_armed <= '0;
            r_pv    <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_use   <= n_use;
            r_armed <= n_armed;
            r_pv    <= n_pv;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pslot <= n_pslot;
        if (in_xfer) begin
            r_op   <= i_opcode;
            r_id   <= i_timer_id;
            r_secs <= i_seconds;
        end
    end

    // Count memory: one write port, one registered read port at the scan index.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ticks[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_ticks[r_idx];
    end

    ost_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ld),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .o_free  (out_free)
    );

    assign o_result_kind = out_res.kind;
    assign o_slot_id     = out_res.slot;
    assign o_ok          = out_res.ok;
    assign o_last        = out_res.last;

`ifndef SYNTHESIS
    // A slot can only be armed while it is allocated.
    a_armed_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_armed & ~r_use) == '0)
        else $error("armed slot is not allocated");

    // Only expiry results can be followed by more results of the same item.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind != KIND_EXPIRY) |-> o_last)
        else $error("single result without last marker");

    // A held expiry exists only while a tick is being processed.
    a_pend_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == ST_TK_UPD || r_state == ST_TK_END
                  || r_state == ST_TK_RD))
        else $error("held expiry outside a tick");

    // An accepted item always blocks input in the cycle after its transfer.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input not stalled after a transfer");
`endif

endmodule

/* hw/rtl/ost_out_reg.sv */
// Output register of the timer bank: holds one result until it is transferred.
// Depends on ost_pkg for the result type.
module ost_out_reg
    import ost_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_free
);

    logic    r_valid;
    t_result r_res;

    // A new result may be loaded when the register is empty or is being drained.
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* bench/one_shot_timer_bank_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for one_shot_timer_bank: directed table, then random traffic.
// Depends on ost_pkg, ost_out_reg and the one_shot_timer_bank RTL; needs nothing else.
module one_shot_timer_bank_test;
    import ost_pkg::*;

    localparam int SLOTS        = 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 18;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 47;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  id;
        logic [31:0] secs;
        bit          typed;
        t_result     answer;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_opcode = OP_TICK;
    logic [3:0]  i_timer_id = 4'd0;
    logic [31:0] i_seconds = 32'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_result_kind;
    logic [3:0]  o_slot_id;
    logic        o_ok;
    logic        o_last;

    // Shadow copy of the timer table.
    bit          slot_taken [SLOTS];
    bit          slot_running [SLOTS];
    bit [31:0]   slot_count [SLOTS];

    t_result     pending_results [$];
    t_row        stim_rows [$];

    int          send_idle_pct = 27;
    int          recv_idle_pct = 85;
    int          hold_left = 0;
    int          cycle_count = 0;
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          directed_count = 0;
    int          results_checked = 0;
    int          most_expiries = 0;
    int          full_answers = 0;

    one_shot_timer_bank #(
        .NUM_SLOTS(SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_opcode(i_opcode),
        .i_timer_id(i_timer_id),
        .i_seconds(i_seconds),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_result_kind(o_result_kind),
        .o_slot_id(o_slot_id),
        .o_ok(o_ok),
        .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Applies one accepted command to the shadow table and queues its answers.
    task automatic advance_timers(input logic [1:0] op, input logic [3:0] id,
                                  input logic [31:0] secs);
        t_result fired [$];
        t_result r;
        int      s;
        bit      found;
        found = 1'b0;
        case (op)
            OP_TICK: begin
                for (s = 0; s < SLOTS; s++) begin
                    if (slot_running[s]) begin
                        if (slot_count[s] <= 32'd1) begin
                            slot_taken[s]   = 1'b0;
                            slot_running[s] = 1'b0;
                            slot_count[s]   = 32'd0;
                            fired.push_back('{kind: KIND_EXPIRY, slot: 4'(s),
                                              ok: 1'b1, last: 1'b0});
                        end else begin
                            slot_count[s] = slot_count[s] - 32'd1;
                        end
                    end
                end
                if (fired.size() > most_expiries) begin
                    most_expiries = fired.size();
                end
                foreach (fired[k]) begin
                    r = fired[k];
                    r.last = (k == fired.size() - 1);
                    pending_results.push_back(r);
                end
            end
            OP_ALLOC: begin
                for (s = 0; s < SLOTS && !found; s++) begin
                    if (!slot_taken[s]) begin
                        slot_taken[s]   = 1'b1;
                        slot_running[s] = 1'b0;
                        slot_count[s]   = 32'd0;
                        pending_results.push_back('{kind: KIND_ALLOC, slot: 4'(s),
                                                    ok: 1'b1, last: 1'b1});
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    full_answers++;
                    pending_results.push_back('{kind: KIND_ALLOC, slot: 4'd0,
                                                ok: 1'b0, last: 1'b1});
                end
            end
            default: begin
                if (slot_taken[id]) begin
                    if (op == OP_START) begin
                        slot_running[id] = 1'b1;
                        slot_count[id]   = secs;
                    end else begin
                        slot_running[id] = 1'b0;
                    end
                end
                pending_results.push_back('{kind: KIND_CMD, slot: id,
                                            ok: slot_taken[id], last: 1'b1});
            end
        endcase
    endtask

    // Offers one command, waits for its transfer, then predicts its answers.
    task automatic send_item(input logic [1:0] op, input logic [3:0] id,
                             input logic [31:0] secs, input bit typed,
                             input t_result answer);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_opcode   <= 2'($urandom);
            i_timer_id <= 4'($urandom);
            i_seconds  <= $urandom;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_timer_id <= id;
        i_seconds  <= secs;
        do @(posedge i_clk); while (o_in_stall);
        advance_timers(op, id, secs);
        // A typed row carries its single answer as written in the table.
        if (typed) begin
            pending_results[pending_results.size() - 1] = answer;
        end
        items_sent++;
    endtask

    // Mostly commands aimed at allocated slots with short counts, some noise.
    task automatic pick_item(output logic [1:0] op, output logic [3:0] id,
                             output logic [31:0] secs);
        int taken_ids [$];
        int w;
        foreach (slot_taken[s]) begin
            if (slot_taken[s]) taken_ids.push_back(s);
        end
        if ($urandom_range(0, 99) < 15) begin
            op   = 2'($urandom);
            id   = 4'($urandom);
            secs = $urandom;
        end else begin
            w = $urandom_range(0, 99);
            if (w < 35)      op = OP_TICK;
            else if (w < 55) op = OP_ALLOC;
            else if (w < 85) op = OP_START;
            else             op = OP_STOP;
            if (taken_ids.size() > 0 && $urandom_range(0, 9) < 8) begin
                id = 4'(taken_ids[$urandom_range(0, taken_ids.size() - 1)]);
            end else begin
                id = 4'($urandom);
            end
            w = $urandom_range(0, 99);
            if (w < 75)      secs = $urandom_range(0, 4);
            else if (w < 90) secs = $urandom;
            else if (w < 95) secs = 32'hFFFF_FFFF;
            else             secs = $urandom_range(5, 40);
        end
    endtask

    // Fills and arms every slot to expire together, with the output held off
    // so that the block backs up and stalls its input.
    task automatic fire_volley();
        int s;
        for (s = 0; s < SLOTS; s++) begin
            if (!slot_taken[s]) begin
                send_item(OP_ALLOC, 4'($urandom), $urandom, 1'b0, '0);
            end
            send_item(OP_START, 4'(s), $urandom_range(0, 1), 1'b0, '0);
        end
        hold_left = HOLD_CYCLES;
        send_item(OP_TICK, 4'($urandom), $urandom, 1'b0, '0);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input bit volley);
        int          first_item;
        logic [1:0]  op;
        logic [3:0]  id;
        logic [31:0] secs;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first_item = items_sent;
        if (volley) fire_volley();
        while (items_sent - first_item < PHASE_ITEMS) begin
            pick_item(op, id, secs);
            send_item(op, id, secs, 1'b0, '0);
        end
    endtask

    function automatic void add_row(input logic [1:0] op, input logic [3:0] id,
                                    input logic [31:0] secs, input bit typed,
                                    input logic [1:0] a_kind, input logic [3:0] a_slot,
                                    input logic a_ok);
        t_row row;
        row.op     = op;
        row.id     = id;
        row.secs   = secs;
        row.typed  = typed;
        row.answer = '{kind: a_kind, slot: a_slot, ok: a_ok, last: 1'b1};
        stim_rows.push_back(row);
    endfunction

    // Output side: random stall, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL one_shot_timer_bank");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{kind: o_result_kind, slot: o_slot_id, ok: o_ok, last: o_last};
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d slot %0d ok %0d last %0d",
                                          got.kind, got.slot, got.ok, got.last));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
                if (got.ok !== want.ok)
                    report_mismatch($sformatf("ok %0d, expected %0d", got.ok, want.ok));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
            end
        end
    end

    initial begin
        // Commands to slots that were never allocated, a full table, both
        // count extremes, a count of zero, stop and reload of a running slot.
        add_row(OP_TICK, 4'd3, 32'd1, 1'b0, KIND_EXPIRY, 4'd0, 1'b1);
        add_row(OP_START, 4'd5, 32'd9, 1'b1, KIND_CMD, 4'd5, 1'b0);
        add_row(OP_STOP, 4'd15, 32'hFFFF_FFFF, 1'b1, KIND_CMD, 4'd15, 1'b0);
        for (int k = 0; k < SLOTS; k++) begin
            add_row(OP_ALLOC, 4'(15 - k), 32'hFFFF_FFFF, 1'b1, KIND_ALLOC, 4'(k), 1'b1);
        end
        add_row(OP_ALLOC, 4'd9, 32'd0, 1'b1, KIND_ALLOC, 4'd0, 1'b0);
        add_row(OP_START, 4'd0, 32'd0, 1'b1, KIND_CMD, 4'd0, 1'b1);
        add_row(OP_START, 4'd15, 32'hFFFF_FFFF, 1'b1, KIND_CMD, 4'd15, 1'b1);
        add_row(OP_START, 4'd7, 32'd1, 1'b1, KIND_CMD, 4'd7, 1'b1);
        add_row(OP_TICK, 4'd0, 32'd0, 1'b0, KIND_EXPIRY, 4'd0, 1'b1);
        add_row(OP_STOP, 4'd15, 32'd0, 1'b1, KIND_CMD, 4'd15, 1'b1);
        add_row(OP_START, 4'd15, 32'd2, 1'b0, KIND_CMD, 4'd15, 1'b1);
        add_row(OP_TICK, 4'd15, 32'd5, 1'b0, KIND_EXPIRY, 4'd0, 1'b1);
        add_row(OP_TICK, 4'd6, 32'd7, 1'b0, KIND_EXPIRY, 4'd0, 1'b1);
        add_row(OP_ALLOC, 4'd2, 32'd3, 1'b1, KIND_ALLOC, 4'd0, 1'b1);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            send_item(stim_rows[k].op, stim_rows[k].id, stim_rows[k].secs,
                      stim_rows[k].typed, stim_rows[k].answer);
        end
        directed_count = items_sent;

        run_phase(27, 85, 1'b0);
        run_phase(85, 27, 1'b0);
        run_phase(0, 0, 1'b1);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands (%0d from the table) and checked %0d results.",
                 items_sent, directed_count, results_checked);
        $display("Largest expiry burst: %0d slots; table-full answers seen: %0d.",
                 most_expiries, full_answers);
        if (mismatch_count == 0) begin
            $display("PASS one_shot_timer_bank");
        end else begin
            $display("FAIL one_shot_timer_bank");
        end
        $finish;
    end

endmodule
